// ----- design/sqe_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the stack/queue engine.
// No dependencies; the controller, datapath and top level import this package.
package sqe_pkg;

	// Command codes carried by req_type.
	typedef enum logic [2:0] {
		REQ_PUSH  = 3'd0,
		REQ_PRINT = 3'd1,
		REQ_PEEK  = 3'd2,
		REQ_POP   = 3'd3,
		REQ_SWAP  = 3'd4
	} req_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_PEEK_EMPTY = 3'd1,
		ST_POP_EMPTY  = 3'd2,
		ST_SWAP_SHORT = 3'd3,
		ST_BAD_ARG    = 3'd4,
		ST_FULL       = 3'd5
	} status_t;

	// Byte address of the mode register.
	localparam logic [1:0] REG_QUEUE_MODE = 2'd0;

	// Read address sources.
	typedef enum logic [1:0] {
		RD_FRONT  = 2'd0,
		RD_SECOND = 2'd1,
		RD_WALK   = 2'd2
	} rd_sel_t;

	// Write address and data sources.
	typedef enum logic [1:0] {
		WR_PUSH        = 2'd0,
		WR_SWAP_FRONT  = 2'd1,
		WR_SWAP_SECOND = 2'd2
	} wr_sel_t;

	// Walk counter operations for print-all.
	typedef enum logic [1:0] {
		WALK_HOLD  = 2'd0,
		WALK_CLEAR = 2'd1,
		WALK_NEXT  = 2'd2
	} walk_op_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic     latch;
		logic     push;
		logic     pop;
		rd_sel_t  rd_sel;
		logic     we;
		wr_sel_t  wr_sel;
		logic     hold;
		walk_op_t walk;
		logic     out_load;
		logic     out_rdata;
		status_t  out_status;
		logic     out_last;
	} sqe_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic empty;
		logic lt_two;
		logic full;
		logic walk_last;
		logic out_free;
	} sqe_sts_t;

endpackage

// ----- design/sqe_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sqe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- design/sqe_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the stack/queue engine.
// Depends on sqe_pkg; drives the datapath through sqe_cmd_t.
module sqe_ctrl
	import sqe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic        arg_ok,
	input  sqe_sts_t    sts,
	output sqe_cmd_t    cmd
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_EXEC   = 7'b0000010,
		S_PRINT  = 7'b0000100,
		S_PEEK   = 7'b0001000,
		S_SWAP_A = 7'b0010000,
		S_SWAP_B = 7'b0100000,
		S_SWAP_W = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	req_t   req_q;
	logic   ok_q;

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_t'(req_type);
			ok_q  <= arg_ok;
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.rd_sel     = RD_FRONT;
		cmd.wr_sel     = WR_PUSH;
		cmd.walk       = WALK_HOLD;
		cmd.out_status = ST_OK;
		cmd.out_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				// Wait until the output register can take a result.
				if (sts.out_free) begin
					state_d = S_IDLE;
					unique case (req_q)
						REQ_PUSH: begin
							cmd.out_load = 1'b1;
							if (sts.full) begin
								cmd.out_status = ST_FULL;
							end else if (!ok_q) begin
								cmd.out_status = ST_BAD_ARG;
							end else begin
								cmd.we   = 1'b1;
								cmd.push = 1'b1;
							end
						end
						REQ_PRINT: begin
							if (!sts.empty) begin
								cmd.walk   = WALK_CLEAR;
								cmd.rd_sel = RD_WALK;
								state_d    = S_PRINT;
							end
						end
						REQ_PEEK: begin
							if (sts.empty) begin
								cmd.out_load   = 1'b1;
								cmd.out_status = ST_PEEK_EMPTY;
							end else begin
								state_d = S_PEEK;
							end
						end
						REQ_POP: begin
							cmd.out_load = 1'b1;
							if (sts.empty) begin
								cmd.out_status = ST_POP_EMPTY;
							end else begin
								cmd.pop = 1'b1;
							end
						end
						REQ_SWAP: begin
							if (sts.lt_two) begin
								cmd.out_load   = 1'b1;
								cmd.out_status = ST_SWAP_SHORT;
							end else begin
								state_d = S_SWAP_A;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_PRINT: begin
				// Read data for the current walk index is valid here; if the
				// output is blocked, the same entry is read again.
				cmd.rd_sel = RD_WALK;
				if (sts.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_rdata = 1'b1;
					cmd.out_last  = sts.walk_last;
					if (sts.walk_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.walk = WALK_NEXT;
					end
				end
			end
			S_PEEK: begin
				cmd.out_load  = 1'b1;
				cmd.out_rdata = 1'b1;
				state_d       = S_IDLE;
			end
			S_SWAP_A: begin
				cmd.hold   = 1'b1;
				cmd.rd_sel = RD_SECOND;
				state_d    = S_SWAP_B;
			end
			S_SWAP_B: begin
				cmd.we     = 1'b1;
				cmd.wr_sel = WR_SWAP_FRONT;
				state_d    = S_SWAP_W;
			end
			S_SWAP_W: begin
				cmd.we       = 1'b1;
				cmd.wr_sel   = WR_SWAP_SECOND;
				cmd.out_load = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- design/sqe_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the stack/queue engine: ring pointers, entry RAM, output register.
// Depends on sqe_pkg and sqe_ram.
module sqe_dp
	import sqe_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               queue_mode,
	input  logic signed [31:0] push_value,
	input  sqe_cmd_t           cmd,
	output sqe_sts_t           sts,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] data_out,
	output logic [2:0]         status,
	output logic               last_of_run
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW:0]   DEPTH_W  = (IW + 1)'(DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [IW-1:0] front_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] walk_q, walk_n;
	logic [31:0]   value_q, hold_q;
	logic          out_valid_q, out_last_q;
	logic [31:0]   out_data_q;
	logic [2:0]    out_status_q;

	logic [IW-1:0] front_inc, front_dec, rd_addr, wr_addr;
	logic [31:0]   wr_data, rd_data;

	// Ring addition with a single conditional wrap.
	function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
		input logic [IW-1:0] off);
		logic [IW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[IW-1:0];
	endfunction

	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + IW'(1);
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - IW'(1);

	always_comb begin
		unique case (cmd.walk)
			WALK_CLEAR: walk_n = '0;
			WALK_NEXT:  walk_n = walk_q + IW'(1);
			default:    walk_n = walk_q;
		endcase
	end

	always_comb begin
		unique case (cmd.rd_sel)
			RD_SECOND: rd_addr = front_inc;
			RD_WALK:   rd_addr = ring_add(front_q, walk_n);
			default:   rd_addr = front_q;
		endcase
	end

	always_comb begin
		unique case (cmd.wr_sel)
			WR_SWAP_FRONT: begin
				wr_addr = front_q;
				wr_data = rd_data;
			end
			WR_SWAP_SECOND: begin
				wr_addr = front_inc;
				wr_data = hold_q;
			end
			default: begin
				wr_addr = queue_mode ? ring_add(front_q, count_q[IW-1:0]) : front_dec;
				wr_data = value_q;
			end
		endcase
	end

	sqe_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (cmd.we),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			walk_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			walk_q <= walk_n;
			if (cmd.push) begin
				count_q <= count_q + CW'(1);
				if (!queue_mode) begin
					front_q <= front_dec;
				end
			end else if (cmd.pop) begin
				count_q <= count_q - CW'(1);
				front_q <= front_inc;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			value_q <= push_value;
		end
		if (cmd.hold) begin
			hold_q <= rd_data;
		end
		if (cmd.out_load) begin
			out_data_q   <= cmd.out_rdata ? rd_data : '0;
			out_status_q <= cmd.out_status;
			out_last_q   <= cmd.out_last;
		end
	end

	assign sts.empty     = (count_q == '0);
	assign sts.lt_two    = (count_q < CW'(2));
	assign sts.full      = (count_q == FULL_CNT);
	assign sts.walk_last = (((CW + 1)'(walk_q) + (CW + 1)'(1)) == (CW + 1)'(count_q));
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign data_out    = out_data_q;
	assign status      = out_status_q;
	assign last_of_run = out_last_q;

endmodule

// ----- design/stack_queue_engine.sv -----
`timescale 1ns / 1ps
// Top level of the stack/queue engine: configuration register and block wiring.
// Depends on sqe_pkg, sqe_ctrl, sqe_dp (which holds sqe_ram).
//
//  Channel   Signals                                   Direction  Transaction when
//  input     in_valid, in_stall, req_type,             in         in_valid && !in_stall
//            push_value, arg_ok
//  output    out_valid, out_stall, data_out,           out        out_valid && !out_stall
//            status, last_of_run
//  config    psel, penable, pwrite, paddr, pwdata,     in/out     psel && penable && pwrite
//            prdata, pready
//
// A command is accepted in S_IDLE and executed in S_EXEC, which loads the result of
// push, pop and the error cases; peek adds S_PEEK for the registered read of the
// single entry RAM, swap adds S_SWAP_A, S_SWAP_B and S_SWAP_W, and print-all loads
// one stored entry per result from S_PRINT. Reset clears the pointers, the count,
// the mode register and the output valid; the entry RAM is not cleared and needs no
// clearing pass. A stalled output holds its result while the engine takes the next
// input transaction; any command then waits in S_EXEC while that result is stalled.
module stack_queue_engine
	import sqe_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// Input channel.
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         req_type,
	input  logic signed [31:0] push_value,
	input  logic               arg_ok,
	// Output channel.
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] data_out,
	output logic [2:0]         status,
	output logic               last_of_run,
	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic     queue_mode_q;
	sqe_cmd_t cmd;
	sqe_sts_t sts;

	// The single mode register is written in the access phase of a write.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr == REG_QUEUE_MODE)) begin
			queue_mode_q <= pwdata[0];
		end
	end

	assign prdata = (paddr == REG_QUEUE_MODE) ? {31'b0, queue_mode_q} : '0;

	// The controller sequences each command; the datapath holds the ring state,
	// the entry RAM and the output register.
	sqe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.arg_ok  (arg_ok),
		.sts     (sts),
		.cmd     (cmd)
	);

	sqe_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.queue_mode (queue_mode_q),
		.push_value (push_value),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_out   (data_out),
		.status     (status),
		.last_of_run(last_of_run)
	);

endmodule

// ----- verif/stack_queue_engine_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for stack_queue_engine: directed and random commands in stack and queue mode.
// Depends on sqe_pkg and the design files; keeps its own model of the entry ring to predict results.
module stack_queue_engine_tb;
	import sqe_pkg::*;

	localparam int DEPTH           = 32;
	// Cycles allowed after the last expected result before the engine counts as idle.
	localparam int SETTLE_CYCLES   = 48;
	// Cycles without any transaction before the run is declared hung.
	localparam int QUIET_LIMIT     = 3000;
	// Length of the long output hold-off used to fill the engine.
	localparam int HOLD_OFF_CYCLES = 300;

	// Command codes the engine ignores.
	localparam logic [2:0] REQ_RSVD_5 = 3'd5;
	localparam logic [2:0] REQ_RSVD_6 = 3'd6;
	localparam logic [2:0] REQ_RSVD_7 = 3'd7;

	localparam logic [31:0] VAL_MAX     = 32'h7fff_ffff;
	localparam logic [31:0] VAL_MIN     = 32'h8000_0000;
	localparam logic [31:0] VAL_ZERO    = 32'h0000_0000;
	localparam logic [31:0] VAL_NEG_ONE = 32'hffff_ffff;

	// One result transaction as the engine should deliver it.
	typedef struct packed {
		logic [31:0] data;
		status_t     st;
		logic        last;
	} result_t;

	// Clock, reset and every block input start at known values.
	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic [2:0]         req_type   = '0;
	logic signed [31:0] push_value = '0;
	logic               arg_ok     = 1'b0;
	logic               out_stall  = 1'b0;
	logic               psel       = 1'b0;
	logic               penable    = 1'b0;
	logic               pwrite     = 1'b0;
	logic [1:0]         paddr      = '0;
	logic [31:0]        pwdata     = '0;

	logic               in_stall;
	logic               out_valid;
	logic signed [31:0] data_out;
	logic [2:0]         status;
	logic               last_of_run;
	logic [31:0]        prdata;
	logic               pready;

	// Model of the engine: the ring of entries, its front pointer, its fill and the mode bit.
	logic [31:0] ring_model [DEPTH];
	int          ring_front = 0;
	int          ring_count = 0;
	logic        mode_model = 1'b0;

	// Results predicted but not yet delivered, oldest first.
	result_t     pending_results [$];

	// Run statistics and knobs shared by the processes below.
	int commands_accepted = 0;
	int results_checked   = 0;
	int fail_count        = 0;
	int peak_fill         = 0;
	int full_results      = 0;
	int quiet_cycles      = 0;
	int send_idle_pct     = 0;
	int recv_stall_pct    = 0;
	int hold_left         = 0;

	logic [31:0] extremes [4] = '{VAL_MAX, VAL_MIN, VAL_ZERO, VAL_NEG_ONE};

	stack_queue_engine #(
		.DEPTH(DEPTH)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.push_value  (push_value),
		.arg_ok      (arg_ok),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_out    (data_out),
		.status      (status),
		.last_of_run (last_of_run),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void expect_result(input logic [31:0] data, input status_t st,
			input logic last);
		pending_results.push_back('{data, st, last});
	endfunction

	// Applies one accepted command to the ring model and queues the results it causes.
	function automatic void predict_command(input logic [2:0] req, input logic [31:0] val,
			input logic ok);
		int          slot;
		int          second;
		int          i;
		logic [31:0] tmp;
		case (req)
			REQ_PUSH: begin
				// The full check wins over the argument check.
				if (ring_count >= DEPTH) begin
					expect_result('0, ST_FULL, 1'b1);
					full_results++;
				end else if (!ok) begin
					expect_result('0, ST_BAD_ARG, 1'b1);
				end else begin
					if (mode_model) begin
						slot = (ring_front + ring_count) % DEPTH;
					end else begin
						ring_front = (ring_front + DEPTH - 1) % DEPTH;
						slot = ring_front;
					end
					ring_model[slot] = val;
					ring_count++;
					if (ring_count > peak_fill)
						peak_fill = ring_count;
					expect_result('0, ST_OK, 1'b1);
				end
			end
			REQ_PRINT: begin
				// An empty store prints nothing at all.
				for (i = 0; i < ring_count; i++)
					expect_result(ring_model[(ring_front + i) % DEPTH], ST_OK,
						i == ring_count - 1);
			end
			REQ_PEEK: begin
				if (ring_count == 0)
					expect_result('0, ST_PEEK_EMPTY, 1'b1);
				else
					expect_result(ring_model[ring_front], ST_OK, 1'b1);
			end
			REQ_POP: begin
				if (ring_count == 0) begin
					expect_result('0, ST_POP_EMPTY, 1'b1);
				end else begin
					ring_front = (ring_front + 1) % DEPTH;
					ring_count--;
					expect_result('0, ST_OK, 1'b1);
				end
			end
			REQ_SWAP: begin
				if (ring_count < 2) begin
					expect_result('0, ST_SWAP_SHORT, 1'b1);
				end else begin
					second = (ring_front + 1) % DEPTH;
					tmp = ring_model[ring_front];
					ring_model[ring_front] = ring_model[second];
					ring_model[second] = tmp;
					expect_result('0, ST_OK, 1'b1);
				end
			end
			default: begin
				// Reserved codes are dropped without a result.
			end
		endcase
	endfunction

	// Every input transaction feeds the model at the edge where it is accepted.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			predict_command(req_type, push_value, arg_ok);
			commands_accepted++;
		end
	end

	// Every output transaction is matched against the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: data_out %0d, status %0d, last_of_run %0b",
					data_out, status, last_of_run);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (data_out !== want.data) begin
					$error("data_out mismatch: expected %0d, actual %0d",
						$signed(want.data), data_out);
					fail_count++;
				end
				if (status !== want.st) begin
					$error("status mismatch: expected %0d, actual %0d", want.st, status);
					fail_count++;
				end
				if (last_of_run !== want.last) begin
					$error("last_of_run mismatch: expected %0b, actual %0b",
						want.last, last_of_run);
					fail_count++;
				end
			end
		end
	end

	// The receiver either sits out a requested hold-off or stalls at the phase's rate.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: a long stretch with no transaction on any port means the engine hung.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$error("no transaction for %0d cycles, %0d results still expected",
				quiet_cycles, pending_results.size());
			$display("status: fail");
			$finish;
		end
	end

	// Offers one command, with random idle cycles ahead of it, and returns at the edge
	// where the engine takes it. The payload holds still while the input is stalled.
	task automatic send_item(input logic [2:0] req, input logic [31:0] val, input logic ok);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= req;
		push_value <= val;
		arg_ok     <= ok;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
	endtask

	// Stops offering commands and waits until every predicted result has come out,
	// then lets the engine finish any command that produces no result.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes the mode register through the configuration port and reads it back.
	// Called only while the engine is idle.
	task automatic write_queue_mode(input logic mode_bit);
		// Setup phase of the write; the upper data bits carry noise the register drops.
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_QUEUE_MODE;
		pwdata  <= ($urandom() & 32'hffff_fffe) | {31'b0, mode_bit};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		mode_model = mode_bit;
		// Read the register back the same way.
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		if (prdata[0] !== mode_bit) begin
			$error("queue_mode read-back mismatch: expected %0b, actual %0b",
				mode_bit, prdata[0]);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Every command on an empty store right after reset, a bad argument and the
	// reserved codes. The mode register is still at its reset value, stack mode.
	task automatic test_empty_errors();
		send_item(REQ_PEEK, VAL_ZERO, 1'b1);
		send_item(REQ_POP, VAL_ZERO, 1'b1);
		send_item(REQ_SWAP, VAL_ZERO, 1'b1);
		send_item(REQ_PRINT, VAL_ZERO, 1'b1);
		send_item(REQ_PUSH, VAL_MAX, 1'b0);
		send_item(REQ_RSVD_5, VAL_NEG_ONE, 1'b1);
		send_item(REQ_RSVD_6, VAL_MIN, 1'b0);
		send_item(REQ_RSVD_7, VAL_MAX, 1'b1);
		settle();
	endtask

	// Stack mode: the extreme values, a swap with one entry, then ordering checks.
	task automatic test_stack_order();
		write_queue_mode(1'b0);
		send_item(REQ_PUSH, VAL_MAX, 1'b1);
		send_item(REQ_SWAP, VAL_ZERO, 1'b1);
		send_item(REQ_PUSH, VAL_MIN, 1'b1);
		send_item(REQ_PUSH, VAL_ZERO, 1'b1);
		send_item(REQ_PUSH, VAL_NEG_ONE, 1'b1);
		send_item(REQ_PRINT, VAL_ZERO, 1'b1);
		send_item(REQ_PEEK, VAL_ZERO, 1'b1);
		send_item(REQ_SWAP, VAL_ZERO, 1'b1);
		send_item(REQ_PRINT, VAL_ZERO, 1'b1);
		send_item(REQ_POP, VAL_ZERO, 1'b1);
		send_item(REQ_POP, VAL_ZERO, 1'b1);
		send_item(REQ_PEEK, VAL_ZERO, 1'b1);
		settle();
	endtask

	// Queue mode on top of what the stack left behind: new values go to the back.
	task automatic test_queue_order();
		write_queue_mode(1'b1);
		send_item(REQ_PUSH, 32'h1234_5678, 1'b1);
		send_item(REQ_PUSH, 32'h8765_4321, 1'b1);
		send_item(REQ_PRINT, VAL_ZERO, 1'b1);
		send_item(REQ_SWAP, VAL_ZERO, 1'b1);
		send_item(REQ_PRINT, VAL_ZERO, 1'b1);
		send_item(REQ_POP, VAL_ZERO, 1'b1);
		send_item(REQ_PEEK, VAL_ZERO, 1'b1);
		settle();
	endtask

	// Fills the store to the last entry in queue mode, then pushes into the full store,
	// once with a bad argument to show that the full check comes first.
	task automatic test_full_store();
		int room;
		room = DEPTH - ring_count;
		repeat (room) send_item(REQ_PUSH, $urandom(), 1'b1);
		send_item(REQ_PUSH, VAL_MAX, 1'b0);
		send_item(REQ_PUSH, VAL_MIN, 1'b1);
		send_item(REQ_PRINT, VAL_ZERO, 1'b1);
		send_item(REQ_POP, VAL_ZERO, 1'b1);
		send_item(REQ_PEEK, VAL_ZERO, 1'b1);
		settle();
	endtask

	// One phase of random commands. push_pct sets how hard the fill level is driven up,
	// so a phase leans either toward filling the store or toward draining it.
	task automatic run_random_phase(input int items, input int push_pct, input int idle_pct,
			input int stall_pct, input logic mode_bit);
		int          sent;
		int          pick;
		logic [2:0]  req;
		logic [31:0] val;
		logic        ok;
		write_queue_mode(mode_bit);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < items) begin
			val = ($urandom_range(4) == 0) ? extremes[$urandom_range(3)] : $urandom();
			ok  = ($urandom_range(9) != 0);
			if ($urandom_range(99) < push_pct) begin
				req = REQ_PUSH;
			end else begin
				pick = $urandom_range(99);
				if (pick < 15)
					req = REQ_PRINT;
				else if (pick < 35)
					req = REQ_PEEK;
				else if (pick < 65)
					req = REQ_POP;
				else if (pick < 95)
					req = REQ_SWAP;
				else
					req = 3'($urandom_range(REQ_RSVD_7, REQ_RSVD_5));
			end
			send_item(req, val, ok);
			// Reserved codes do nothing, so they do not count toward the phase.
			if (req <= REQ_SWAP)
				sent++;
		end
		settle();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering at full
	// rate, so the engine's output fills and its input stall has to come up.
	task automatic test_output_holdoff();
		int          n;
		logic [2:0]  req;
		write_queue_mode(1'b0);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = HOLD_OFF_CYCLES;
		for (n = 0; n < 40; n++) begin
			case ($urandom_range(3))
				0: req = REQ_PEEK;
				1: req = REQ_POP;
				2: req = REQ_SWAP;
				default: req = REQ_PUSH;
			endcase
			send_item(req, $urandom(), 1'b1);
		end
		settle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_errors();
		test_stack_order();
		test_queue_order();
		test_full_store();
		// Idling phases: none, sender idle, receiver stalling, both.
		run_random_phase(37, 60, 0, 0, 1'b0);
		run_random_phase(37, 20, 52, 0, 1'b1);
		run_random_phase(37, 60, 0, 52, 1'b1);
		run_random_phase(37, 20, 30, 30, 1'b0);
		test_output_holdoff();

		$display("Ran %0d commands and checked %0d results in stack and queue mode,",
			commands_accepted, results_checked);
		$display("with four idling phases and a long hold-off; peak fill %0d, %0d full pushes.",
			peak_fill, full_results);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
